// ===== sv/mh2_pkg.sv =====
// Shared types, constants and helpers for the streaming MurmurHash2 block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package mh2_pkg;

    // Mixing constants
    localparam logic [31:0] MIX_MULT    = 32'h5bd1_e995;
    localparam int unsigned WORD_SHIFT  = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    // Datapath operation codes
    typedef logic [2:0] dp_op_t;
    localparam dp_op_t OP_NONE  = 3'd0;
    localparam dp_op_t OP_WORD1 = 3'd1;  // k = w * m
    localparam dp_op_t OP_WORD2 = 3'd2;  // k = (k ^ k >> 24) * m
    localparam dp_op_t OP_WORD3 = 3'd3;  // acc = acc * m ^ k
    localparam dp_op_t OP_TAIL  = 3'd4;  // acc = (acc ^ tail) * m
    localparam dp_op_t OP_FIN   = 3'd5;  // hash = avalanche(acc)

    // Controller to datapath commands
    typedef struct packed {
        logic   capture;   // latch the incoming beat's word
        logic   load_acc;  // start a key: acc = seed ^ length
        dp_op_t op;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_hold;    // result register full and not taken this cycle
    } dp_stat_t;

    // Byte mask for a word of nb valid bytes; a full word keeps all bits
    function automatic logic [31:0] tail_mask(input logic [2:0] nb);
        logic [31:0] mask;
        case (nb)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mh2_datapath.sv =====
// Datapath: seed, accumulator, scramble and result registers around one
// shared constant multiplier. Depends on mh2_pkg; driven by mh2_ctrl.
`default_nettype none

module mh2_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mh2_pkg::dp_cmd_t  cmd,
    output mh2_pkg::dp_stat_t      stat,
    input  wire logic              seed_wr_en,
    input  wire logic [31:0]       seed_wr_data,
    input  wire logic [31:0]       key_length,
    input  wire logic [31:0]       data_word,
    input  wire logic [2:0]        word_bytes,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            hash_value
);
    import mh2_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] acc_reg,  acc_next;
    logic [31:0] k_reg,    k_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] hash_reg, hash_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] mul_a;
    logic [31:0] product;

    // Hold the seed; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (seed_wr_en)
            seed_reg <= seed_wr_data;
    end

    // Select the multiplier operand for the current step
    always_comb
    begin
        case (cmd.op)
            OP_WORD1: mul_a = word_reg;
            OP_WORD2: mul_a = k_reg ^ (k_reg >> WORD_SHIFT);
            OP_WORD3: mul_a = acc_reg;
            OP_TAIL:  mul_a = acc_reg ^ word_reg;
            OP_FIN:   mul_a = acc_reg ^ (acc_reg >> FIN_SHIFT_A);
            default:  mul_a = acc_reg;
        endcase
    end

    assign product = mul_a * MIX_MULT;

    // Advance the working registers
    always_comb
    begin
        acc_next  = acc_reg;
        k_next    = k_reg;
        word_next = word_reg;
        hash_next = hash_reg;
        if (cmd.capture)
            word_next = data_word & tail_mask(word_bytes);
        if (cmd.load_acc)
            acc_next = seed_reg ^ key_length;
        case (cmd.op)
            OP_WORD1: k_next    = product;
            OP_WORD2: k_next    = product;
            OP_WORD3: acc_next  = product ^ k_reg;
            OP_TAIL:  acc_next  = product;
            OP_FIN:   hash_next = product ^ (product >> FIN_SHIFT_B);
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            k_reg    <= '0;
            word_reg <= '0;
            hash_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            k_reg    <= k_next;
            word_reg <= word_next;
            hash_reg <= hash_next;
        end
    end

    // Result beat: set on finish, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.op == OP_FIN)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign stat.out_hold = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign hash_value    = hash_reg;

endmodule

`default_nettype wire

// ===== sv/mh2_ctrl.sv =====
// Controller: sequences one input beat through the datapath steps and
// tracks whether a key is open. Depends on mh2_pkg; drives mh2_datapath.
`default_nettype none

module mh2_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              first,
    input  wire logic [2:0]        word_bytes,
    input  wire logic              last,
    output mh2_pkg::dp_cmd_t       cmd,
    input  wire mh2_pkg::dp_stat_t stat
);
    import mh2_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_W1   = 3'd1;
    localparam logic [2:0] ST_W2   = 3'd2;
    localparam logic [2:0] ST_W3   = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg,  state_next;
    logic       in_key_reg, in_key_next;
    logic       last_reg,   last_next;
    logic       accept;
    logic       full_word;
    logic       tail_word;
    logic [2:0] after_mix;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign full_word = word_bytes[2];
    assign tail_word = !word_bytes[2] && (word_bytes != 3'd0);
    assign after_mix = last_reg ? ST_FIN : ST_IDLE;

    // Step through the mixing sequence for the captured beat
    always_comb
    begin
        state_next   = state_reg;
        in_key_next  = in_key_reg;
        last_next    = last_reg;
        cmd.capture  = 1'b0;
        cmd.load_acc = 1'b0;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                // Drop beats that arrive outside a key
                if (accept && (first || in_key_reg))
                begin
                    cmd.capture  = 1'b1;
                    cmd.load_acc = first;
                    last_next    = last;
                    in_key_next  = !last;
                    if (full_word)
                        state_next = ST_W1;
                    else if (tail_word)
                        state_next = ST_TAIL;
                    else if (last)
                        state_next = ST_FIN;
                end
            end
            ST_W1:
            begin
                cmd.op     = OP_WORD1;
                state_next = ST_W2;
            end
            ST_W2:
            begin
                cmd.op     = OP_WORD2;
                state_next = ST_W3;
            end
            ST_W3:
            begin
                cmd.op     = OP_WORD3;
                state_next = after_mix;
            end
            ST_TAIL:
            begin
                cmd.op     = OP_TAIL;
                state_next = after_mix;
            end
            ST_FIN:
            begin
                // Wait until the result register is free
                if (!stat.out_hold)
                begin
                    cmd.op     = OP_FIN;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            in_key_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_key_reg <= in_key_next;
            last_reg   <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/murmur2_hash_stream_top.sv =====
// Top level of the streaming 32-bit MurmurHash2 hasher.
// Depends on mh2_pkg, mh2_ctrl and mh2_datapath.
//
// Keys arrive as little-endian 32-bit beats; the beat with first set loads
// the accumulator with seed ^ key_length, the beat with last set produces
// one hash_value beat. A beat is taken while idle and then occupies the
// block for the steps of the single shared 32x32 constant multiplier:
// three mixing steps for a full word, one for a 1-3 byte tail, none for an
// empty beat, plus one finishing step on the last beat. The result sits
// in an output register, so the next key can start while it waits to be
// taken; the finishing step stalls only if the previous hash is still
// unread. Beats with first clear outside a key are dropped. Write the seed
// only while no key is in progress.
`default_nettype none

module murmur2_hash_stream_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_wr_en,
    input  wire logic [31:0] seed_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        first,
    input  wire logic [31:0] key_length,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  word_bytes,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);
    import mh2_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mh2_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first      (first),
        .word_bytes (word_bytes),
        .last       (last),
        .cmd        (cmd),
        .stat       (stat)
    );

    mh2_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .key_length   (key_length),
        .data_word    (data_word),
        .word_bytes   (word_bytes),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

endmodule

`default_nettype wire

// ===== sv/mh2_checker.sv =====
// Port-level checks for murmur2_hash_stream_top, attached by bind.
// No package dependency; sees the top level's ports only.
`default_nettype none

module mh2_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        first,
    input wire logic [2:0]  word_bytes,
    input wire logic        last,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] hash_value
);

    // A stalled result beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value))
        else $error("result beat changed while stalled");

    // A full word starting a key keeps the input closed for three mixing steps
    a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && first && word_bytes[2]
        |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input reopened during word mixing");

    // An empty single-beat key, with no result pending, yields a hash after the finishing step
    a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && first && last && (word_bytes == 3'd0) && !out_valid
        |=> !in_ready ##1 out_valid)
        else $error("empty key did not produce a hash");

    // Inputs reopen after an empty non-final beat
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last && (word_bytes == 3'd0) |=> in_ready)
        else $error("empty beat stalled the input");

endmodule

bind murmur2_hash_stream_top mh2_checker u_mh2_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .first      (first),
    .word_bytes (word_bytes),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for murmur2_hash_stream_top: keys streamed as beats,
// hashes checked against an in-bench MurmurHash2 predictor under random stalls.
// Depends on mh2_pkg and the murmur2_hash_stream_top RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mh2_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic        first;
        logic [31:0] key_length;
        logic [31:0] data_word;
        logic [2:0]  word_bytes;
        logic        last;
    } beat_t;

    typedef enum logic [1:0] {EXP_MODEL, EXP_VALUE, EXP_NONE} exp_kind_t;

    typedef struct packed {
        beat_t       beat;
        exp_kind_t   kind;
        logic [31:0] hash;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        seed_wr_en;
    logic [31:0] seed_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic        first;
    logic [31:0] key_length;
    logic [31:0] data_word;
    logic [2:0]  word_bytes;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash_value;

    // Predictor state
    logic [31:0] model_seed;
    logic [31:0] model_acc;
    logic        model_in_key;

    logic [31:0] hash_expect_q [$];
    int          hash_errors;
    int          hashes_seen;
    int          beats_taken;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_reqs;

    murmur2_hash_stream_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first        (first),
        .key_length   (key_length),
        .data_word    (data_word),
        .word_bytes   (word_bytes),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scramble one full word and fold it into the accumulator
    function automatic logic [31:0] mix_word(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] k;
        k = w * MIX_MULT;
        k = k ^ (k >> WORD_SHIFT);
        k = k * MIX_MULT;
        return (acc * MIX_MULT) ^ k;
    endfunction

    // Final avalanche of the accumulator
    function automatic logic [31:0] avalanche(input logic [31:0] a);
        a = a ^ (a >> FIN_SHIFT_A);
        a = a * MIX_MULT;
        a = a ^ (a >> FIN_SHIFT_B);
        return a;
    endfunction

    // Advance the predictor by one accepted beat
    function automatic void murmur_step(input beat_t b, output logic taken,
                                        output logic emit, output logic [31:0] h);
        logic [2:0]  nb;
        logic [31:0] mask;
        taken = 1'b0;
        emit  = 1'b0;
        h     = '0;
        if (b.first)
        begin
            model_acc    = model_seed ^ b.key_length;
            model_in_key = 1'b1;
        end
        else if (!model_in_key)
        begin
            return;
        end
        taken = 1'b1;
        nb = (b.word_bytes > 3'd4) ? 3'd4 : b.word_bytes;
        if (nb == 3'd4)
        begin
            model_acc = mix_word(model_acc, b.data_word);
        end
        else if (nb != 3'd0)
        begin
            mask      = 32'hffff_ffff >> (8 * (4 - nb));
            model_acc = (model_acc ^ (b.data_word & mask)) * MIX_MULT;
        end
        if (b.last)
        begin
            model_in_key = 1'b0;
            emit         = 1'b1;
            h            = avalanche(model_acc);
        end
    endfunction

    // Offer one beat after a random gap, hold it until taken, then predict
    task automatic send_beat(input beat_t b, input exp_kind_t kind,
                             input logic [31:0] typed, output logic taken);
        logic        emit;
        logic [31:0] h;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        first      <= b.first;
        key_length <= b.key_length;
        data_word  <= b.data_word;
        word_bytes <= b.word_bytes;
        last       <= b.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        murmur_step(b, taken, emit, h);
        if (emit && kind != EXP_NONE)
            hash_expect_q = {hash_expect_q, (kind == EXP_VALUE) ? typed : h};
        if (taken)
            beats_taken++;
    endtask

    // Hold the input until every hash is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= value;
        @(posedge clk);
        seed_wr_en   <= 1'b0;
        model_seed = value;
    endtask

    // Stream one well-formed key, with occasional empty beats, oversized
    // byte counts, early tails, wrong lengths and abandoned keys
    task automatic send_key(output int n_taken);
        int    len;
        int    left;
        int    nb;
        beat_t b;
        logic  taken;
        logic  first_flag;
        n_taken = 0;
        len = ($urandom_range(15) == 0) ? $urandom_range(200) : $urandom_range(24);
        b.key_length = ($urandom_range(15) == 0) ? $urandom : 32'(len);
        left = len;
        first_flag = 1'b1;
        while (1)
        begin
            if ($urandom_range(24) == 0)
            begin
                b.first      = first_flag;
                b.data_word  = $urandom;
                b.word_bytes = 3'd0;
                b.last       = 1'b0;
                send_beat(b, EXP_MODEL, '0, taken);
                n_taken += taken;
                first_flag = 1'b0;
            end
            nb = (left >= 4) ? 4 : left;
            left -= nb;
            b.first      = first_flag;
            b.data_word  = $urandom;
            b.word_bytes = 3'(nb);
            b.last       = (left == 0);
            if (nb == 4 && $urandom_range(7) == 0)
                b.word_bytes = 3'($urandom_range(7, 5));
            else if (nb == 4 && left > 0 && $urandom_range(29) == 0)
                b.word_bytes = 3'($urandom_range(3, 1));
            send_beat(b, EXP_MODEL, '0, taken);
            n_taken += taken;
            first_flag = 1'b0;
            if (b.last || $urandom_range(39) == 0)
                break;
        end
    endtask

    // Mostly whole keys with some stray beats; close any open key at the end
    task automatic run_random(input int n_beats);
        int    done;
        int    n;
        beat_t b;
        logic  taken;
        done = 0;
        while (done < n_beats)
        begin
            if ($urandom_range(99) < 8)
            begin
                b.first      = ($urandom_range(3) == 0);
                b.key_length = $urandom;
                b.data_word  = $urandom;
                b.word_bytes = 3'($urandom_range(7));
                b.last       = 1'($urandom_range(1));
                send_beat(b, EXP_MODEL, '0, taken);
                done += taken;
            end
            else
            begin
                send_key(n);
                done += n;
            end
        end
        if (model_in_key)
        begin
            b = '{first: 1'b0, key_length: '0, data_word: $urandom,
                  word_bytes: 3'd0, last: 1'b1};
            send_beat(b, EXP_MODEL, '0, taken);
        end
        drain();
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                holds_done = hold_reqs;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each hash beat with the oldest expectation
    always @(posedge clk)
    begin : hash_check
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                $display("%0t: unexpected hash, expected none, got %08h", $time, hash_value);
                hash_errors++;
            end
            else
            begin
                want = hash_expect_q.pop_front();
                hashes_seen++;
                if (hash_value !== want)
                begin
                    $display("%0t: hash mismatch, expected %08h, got %08h",
                             $time, want, hash_value);
                    hash_errors++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d hashes still pending", $time, hash_expect_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin : main
        dir_row_t dir_rows [14];
        logic     taken;
        in_valid      = 1'b0;
        first         = 1'b0;
        key_length    = '0;
        data_word     = '0;
        word_bytes    = '0;
        last          = 1'b0;
        seed_wr_en    = 1'b0;
        seed_wr_data  = '0;
        rst_n         = 1'b0;
        model_seed    = '0;
        model_acc     = '0;
        model_in_key  = 1'b0;
        hash_errors   = 0;
        hashes_seen   = 0;
        beats_taken   = 0;
        cycle_count   = 0;
        hold_reqs     = 0;
        send_idle_pct = 7;
        recv_idle_pct = 76;

        // Directed beats: empty key at seed zero hashes to zero, stray beats
        // give nothing, then empty, early-tail, oversized and restart cases
        dir_rows = '{
            '{'{1'b1, 32'd0,          32'h0000_0000, 3'd0, 1'b1}, EXP_VALUE, 32'h0},
            '{'{1'b0, 32'hffff_ffff,  32'hffff_ffff, 3'd4, 1'b1}, EXP_NONE,  32'h0},
            '{'{1'b1, 32'd4,          32'hffff_ffff, 3'd4, 1'b0}, EXP_MODEL, 32'h0},
            '{'{1'b0, 32'd0,          32'hdead_beef, 3'd0, 1'b0}, EXP_MODEL, 32'h0},
            '{'{1'b0, 32'd0,          32'h1234_5678, 3'd1, 1'b0}, EXP_MODEL, 32'h0},
            '{'{1'b0, 32'd0,          32'h0000_0000, 3'd4, 1'b0}, EXP_MODEL, 32'h0},
            '{'{1'b0, 32'd0,          32'h8000_0001, 3'd7, 1'b1}, EXP_MODEL, 32'h0},
            '{'{1'b1, 32'hffff_ffff,  32'ha5a5_a5a5, 3'd5, 1'b0}, EXP_MODEL, 32'h0},
            '{'{1'b1, 32'h8000_0000,  32'h5a5a_5a5a, 3'd6, 1'b0}, EXP_MODEL, 32'h0},
            '{'{1'b0, 32'd0,          32'hffff_ffff, 3'd2, 1'b1}, EXP_MODEL, 32'h0},
            '{'{1'b1, 32'd3,          32'hff_abcdef, 3'd3, 1'b1}, EXP_MODEL, 32'h0},
            '{'{1'b1, 32'd100,        32'h0000_0000, 3'd4, 1'b1}, EXP_MODEL, 32'h0},
            '{'{1'b0, 32'd0,          32'h0f0f_0f0f, 3'd4, 1'b0}, EXP_NONE,  32'h0},
            '{'{1'b1, 32'hffff_ffff,  32'hffff_ffff, 3'd4, 1'b1}, EXP_MODEL, 32'h0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_seed(32'h0);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].kind, dir_rows[i].hash, taken);
        drain();

        // Sender mostly busy, receiver mostly stalled
        write_seed(32'hffff_ffff);
        run_random(600);

        // Sender mostly idle, receiver mostly ready; pause mid-way until empty
        send_idle_pct = 76;
        recv_idle_pct = 7;
        write_seed($urandom);
        run_random(300);
        run_random(300);

        // No idling; open with a long receiver hold so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed(32'h8000_0001);
        hold_reqs++;
        run_random(600);

        $display("Streamed %0d key beats and checked %0d hashes over four seeds,",
                 beats_taken, hashes_seen);
        $display("three stall mixes, a long output hold-off and a full input pause.");
        if (hash_errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== murmur2_hash_stream_top.f =====
sv/mh2_pkg.sv
sv/mh2_datapath.sv
sv/mh2_ctrl.sv
sv/murmur2_hash_stream_top.sv
sv/mh2_checker.sv
dv/testbench.sv
